### sv/qph_pkg.sv
// package for the quadratic probe hash table: sizes, codes, slot layout and fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qph_pkg;
  localparam int SLOTS      = 64;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_BYTES  = 8;
  localparam int KEY_W      = 64;
  localparam int VALUE_BITS = 32;
  localparam int HASH_W     = 12;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_FULL      = 2'd2;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_DELETED  = 2'd2;

  localparam logic [1:0] ADDR_SIZE = 2'd0;

  typedef struct packed {
    logic [1:0]            st;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] val;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HMUL, S_HRED, S_PRD, S_PCHK, S_RES
  } state_t;
endpackage
`default_nettype wire

### sv/qph_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module qph_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] addr,
  input  wire logic [W-1:0]         wdata,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/quadratic_probe_hash_table_unit.sv
// top level of the quadratic probe hash table: apb size register, hashing, probe fsm
// depends on qph_pkg and qph_ram
`timescale 1ns / 1ps
`default_nettype none
// usage
//   apb port holds one register, table_size_in_use, at byte address 0 (0 acts as 1 and
//   values above 64 as 64; the low 7 bits read back as written); write only while idle
//   input channel in_valid/in_ready carries req_type, key and value; output channel
//   out_valid/out_ready carries status, found_value and occupied_count, one per item
// flow
//   one item is handled at a time: an accept step in idle; per key byte up to the first
//   zero byte, one multiply-add, then a 3-bit-per-cycle remainder unit; per probe, a
//   slot ram read, then compare and write back; last, the result register loads
//   an undefined request goes from idle straight to the result state, answering not found
// reset
//   synchronous rst clears the slot valid flags (every slot reads empty), the
//   occupied count and the output valid flag, and sets the size to 64
// stall
//   a finished result waits in the result state until the output register frees,
//   in_ready stays low until the fsm is back in idle
module quadratic_probe_hash_table_unit
  import qph_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [1:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            req_type,
  input  wire logic [KEY_W-1:0]      key,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [1:0]            status,
  output logic      [VALUE_BITS-1:0] found_value,
  output logic      [CNT_W-1:0]      occupied_count
);
  state_t state, state_next;

  logic [CNT_W-1:0]      cfg_size;
  logic [CNT_W-1:0]      eff_size;
  logic [CNT_W-1:0]      size_r;
  logic [CNT_W-1:0]      cnt;
  logic [SLOTS-1:0]      valid;

  // request held during the walk
  logic [1:0]            req;
  logic [KEY_W-1:0]      kn;
  logic [VALUE_BITS-1:0] val;
  logic [3:0]            nb;
  logic [2:0]            b;
  logic [IDX_W-1:0]      h;
  logic [HASH_W-1:0]     r;
  logic [1:0]            rc;

  // probe walk
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      inc;
  logic [CNT_W-1:0]      pi;
  logic                  have_del;
  logic [IDX_W-1:0]      del_at;
  logic [1:0]            res_st;
  logic [VALUE_BITS-1:0] res_val;

  // slot ram
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  slot_t                 ram_wdata, ram_rdata;

  qph_ram #(.W($bits(slot_t)), .D(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // apb
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_SIZE);
  assign prdata = (paddr == ADDR_SIZE) ? {{(32-CNT_W){1'b0}}, cfg_size} : 32'd0;

  always_comb begin
    eff_size = cfg_size;
    if (cfg_size == '0) eff_size = CNT_W'(1);
    if (cfg_size > CNT_W'(SLOTS)) eff_size = CNT_W'(SLOTS);
  end

  // key normalization: cut at the first zero byte
  logic [KEY_W-1:0] norm_key;
  logic [3:0]       norm_nb;
  always_comb begin
    logic stop;
    stop     = 1'b0;
    norm_key = '0;
    norm_nb  = '0;
    for (int j = 0; j < KEY_BYTES; j++) begin
      if (key[8*j +: 8] == 8'd0) stop = 1'b1;
      if (!stop) begin
        norm_key[8*j +: 8] = key[8*j +: 8];
        norm_nb            = 4'(j + 1);
      end
    end
  end

  // remainder unit: three restoring steps per cycle, shift 11 down to 0
  logic [HASH_W-1:0] r_red;
  always_comb begin
    logic [18:0] d;
    logic [3:0]  sh;
    r_red = r;
    for (int j = 0; j < 3; j++) begin
      sh = 4'(11 - 3 * int'(rc) - j);
      d  = {12'd0, size_r} << sh;
      if ({7'd0, r_red} >= d) r_red = HASH_W'({7'd0, r_red} - d);
    end
  end

  // next probe position: idx += inc, inc += 2, both mod size
  logic [CNT_W-1:0] idx_adv;
  logic [CNT_W:0]   inc_adv;
  always_comb begin
    idx_adv = {1'b0, idx} + inc;
    if (idx_adv >= size_r) idx_adv = idx_adv - size_r;
    inc_adv = {1'b0, inc} + (CNT_W+1)'(2);
    if (inc_adv >= {1'b0, size_r}) inc_adv = inc_adv - {1'b0, size_r};
    if (inc_adv >= {1'b0, size_r}) inc_adv = inc_adv - {1'b0, size_r};
  end

  // probe check
  logic [1:0]            st_eff;
  logic                  match, last, is_del, have_del_n;
  logic [IDX_W-1:0]      del_at_n;
  logic                  ck_fin, ck_we, ck_inc, ck_dec;
  logic [IDX_W-1:0]      ck_addr;
  slot_t                 ck_word;
  logic [1:0]            ck_res;
  logic [VALUE_BITS-1:0] ck_fval;

  always_comb begin
    st_eff     = valid[idx] ? ram_rdata.st : ST_EMPTY;
    match      = (st_eff == ST_OCCUPIED) && (ram_rdata.key == kn);
    last       = (pi == size_r - CNT_W'(1));
    is_del     = (st_eff == ST_DELETED);
    have_del_n = have_del || is_del;
    del_at_n   = have_del ? del_at : idx;
    ck_fin     = 1'b0;
    ck_we      = 1'b0;
    ck_inc     = 1'b0;
    ck_dec     = 1'b0;
    ck_addr    = idx;
    ck_word    = '{st: ST_OCCUPIED, key: kn, val: val};
    ck_res     = RES_NOT_FOUND;
    ck_fval    = '0;
    if (req == REQ_INSERT) begin
      if (st_eff == ST_EMPTY) begin
        ck_fin  = 1'b1;
        ck_we   = 1'b1;
        ck_inc  = 1'b1;
        ck_addr = del_at_n;
        ck_res  = RES_OK;
      end else if (match) begin
        ck_fin = 1'b1;
        ck_we  = 1'b1;
        ck_res = RES_OK;
      end else if (last) begin
        ck_fin = 1'b1;
        if (have_del_n) begin
          ck_we   = 1'b1;
          ck_inc  = 1'b1;
          ck_addr = del_at_n;
          ck_res  = RES_OK;
        end else begin
          ck_res = RES_FULL;
        end
      end
    end else begin
      if (st_eff == ST_EMPTY) begin
        ck_fin = 1'b1;
      end else if (match) begin
        ck_fin = 1'b1;
        ck_res = RES_OK;
        if (req == REQ_SEARCH) begin
          ck_fval = ram_rdata.val;
        end else begin
          ck_we   = 1'b1;
          ck_dec  = (cnt != '0);
          ck_word = '{st: ST_DELETED, key: '0, val: '0};
        end
      end else if (last) begin
        ck_fin = 1'b1;
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // fsm next state and ram control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = idx;
    ram_wdata  = ck_word;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (req_type != REQ_INSERT && req_type != REQ_SEARCH &&
              req_type != REQ_DELETE) begin
            state_next = S_RES;
          end else if (norm_nb == 4'd0) begin
            state_next = S_PRD;
          end else begin
            state_next = S_HMUL;
          end
        end
      end
      S_HMUL: state_next = S_HRED;
      S_HRED: begin
        if (rc == 2'd3) begin
          state_next = ({1'b0, b} + 4'd1 == nb) ? S_PRD : S_HMUL;
        end
      end
      S_PRD: state_next = S_PCHK;
      S_PCHK: begin
        ram_we   = ck_we;
        ram_addr = ck_we ? ck_addr : idx;
        state_next = ck_fin ? S_RES : S_PRD;
      end
      S_RES: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg_size  <= CNT_W'(SLOTS);
      cnt       <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) cfg_size <= pwdata[CNT_W-1:0];
      // a result taken this cycle frees the register unless the next one loads now
      if (out_valid && out_ready && !(state == S_RES && out_free)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          req      <= req_type;
          kn       <= norm_key;
          nb       <= norm_nb;
          val      <= value;
          b        <= '0;
          h        <= '0;
          size_r   <= eff_size;
          idx      <= '0;
          inc      <= (eff_size == CNT_W'(1)) ? '0 : CNT_W'(1);
          pi       <= '0;
          have_del <= 1'b0;
          del_at   <= '0;
          res_st   <= RES_NOT_FOUND;
          res_val  <= '0;
        end
        S_HMUL: begin
          // h*31 + byte stays below 2^12
          r  <= HASH_W'({6'd0, h} * 12'd31) + {4'd0, kn[8*b +: 8]};
          rc <= '0;
        end
        S_HRED: begin
          r  <= r_red;
          rc <= rc + 2'd1;
          if (rc == 2'd3) begin
            h   <= r_red[IDX_W-1:0];
            idx <= r_red[IDX_W-1:0];
            b   <= b + 3'd1;
          end
        end
        S_PCHK: begin
          if (ck_we) begin
            valid[ck_addr] <= 1'b1;
          end
          if (ck_inc) cnt <= cnt + CNT_W'(1);
          if (ck_dec) cnt <= cnt - CNT_W'(1);
          if (ck_fin) begin
            res_st  <= ck_res;
            res_val <= ck_fval;
          end else begin
            // remember the first tombstone passed
            have_del <= have_del_n;
            del_at   <= del_at_n;
            idx      <= idx_adv[IDX_W-1:0];
            inc      <= inc_adv[CNT_W-1:0];
            pi       <= pi + CNT_W'(1);
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= res_st;
            found_value    <= res_val;
            occupied_count <= cnt;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/qph_checker.sv
// port-level checker for the quadratic probe hash table, bound to the top level
// depends on qph_pkg
`timescale 1ns / 1ps
`default_nettype none
module qph_checker
  import qph_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            status,
  input wire logic [VALUE_BITS-1:0] found_value,
  input wire logic [CNT_W-1:0]      occupied_count
);
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == RES_OK || status == RES_NOT_FOUND || status == RES_FULL))
    else $error("undefined status code");

  a_value_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_value != '0) |-> (status == RES_OK))
    else $error("value returned without a hit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupied_count <= CNT_W'(SLOTS)))
    else $error("occupied count above slot count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(found_value)))
    else $error("stalled result changed");
endmodule

bind quadratic_probe_hash_table_unit qph_checker u_qph_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .found_value    (found_value),
  .occupied_count (occupied_count)
);
`default_nettype wire

### dv/quadratic_probe_hash_table_unit_test.sv
// self-checking testbench for quadratic_probe_hash_table_unit: directed and random
// insert/search/delete traffic checked against an in-bench table model; needs qph_pkg
`timescale 1ns / 1ps
module quadratic_probe_hash_table_unit_test;
  import qph_pkg::*;

  localparam logic [1:0] REQ_UNDEFINED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [1:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            req_type = '0;
  logic [KEY_W-1:0]      key = '0;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic [CNT_W-1:0]      occupied_count;

  quadratic_probe_hash_table_unit i_dut (.*);

  typedef struct packed {
    logic [1:0]            st;
    logic [VALUE_BITS-1:0] fv;
    logic [CNT_W-1:0]      cnt;
  } answer_t;

  // table model
  logic [1:0]            tbl_state [SLOTS];
  logic [KEY_W-1:0]      tbl_key   [SLOTS];
  logic [VALUE_BITS-1:0] tbl_val   [SLOTS];
  int unsigned           tbl_count;
  logic [6:0]            size_reg;

  answer_t answers_due [$];
  int      fail_count;
  int      send_idle_pct;
  int      recv_stall_pct;
  bit      recv_hold;

  // pool of keys so searches and deletes actually hit
  logic [KEY_W-1:0] key_pool [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("quadratic_probe_hash_table_unit regression: fail");
    $finish;
  end

  function automatic answer_t table_apply(logic [1:0] req, logic [KEY_W-1:0] k,
                                          logic [VALUE_BITS-1:0] v);
    int unsigned      sz;
    int unsigned      home;
    int unsigned      idx;
    int unsigned      del_at;
    bit               have_del;
    bit               done;
    logic [KEY_W-1:0] nk;
    logic [7:0]       byt;
    answer_t          a;
    sz = (size_reg == 0) ? 1 : ((size_reg > SLOTS) ? SLOTS : size_reg);
    nk = '0;
    home = 0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      byt = k[8*b +: 8];
      if (byt == 0) break;
      nk[8*b +: 8] = byt;
      home = (home * 31 + byt) % sz;
    end
    a.st = RES_NOT_FOUND;
    a.fv = '0;
    have_del = 1'b0;
    del_at = 0;
    done = 1'b0;
    if (req == REQ_INSERT) begin
      for (int unsigned i = 0; i < sz && !done; i++) begin
        idx = (home + i * i) % sz;
        if (tbl_state[idx] == ST_EMPTY) begin
          if (have_del) idx = del_at;
          tbl_key[idx] = nk;
          tbl_val[idx] = v;
          tbl_state[idx] = ST_OCCUPIED;
          tbl_count++;
          a.st = RES_OK;
          done = 1'b1;
        end else if (tbl_state[idx] == ST_OCCUPIED) begin
          if (tbl_key[idx] == nk) begin
            tbl_val[idx] = v;
            a.st = RES_OK;
            done = 1'b1;
          end
        end else if (!have_del) begin
          have_del = 1'b1;
          del_at = idx;
        end
      end
      if (!done) begin
        if (have_del) begin
          tbl_key[del_at] = nk;
          tbl_val[del_at] = v;
          tbl_state[del_at] = ST_OCCUPIED;
          tbl_count++;
          a.st = RES_OK;
        end else begin
          a.st = RES_FULL;
        end
      end
    end else if (req == REQ_SEARCH || req == REQ_DELETE) begin
      for (int unsigned i = 0; i < sz; i++) begin
        idx = (home + i * i) % sz;
        if (tbl_state[idx] == ST_EMPTY) break;
        if (tbl_state[idx] == ST_OCCUPIED && tbl_key[idx] == nk) begin
          a.st = RES_OK;
          if (req == REQ_SEARCH) begin
            a.fv = tbl_val[idx];
          end else begin
            tbl_state[idx] = ST_DELETED;
            if (tbl_count > 0) tbl_count--;
          end
          break;
        end
      end
    end
    a.cnt = tbl_count[CNT_W-1:0];
    return a;
  endfunction

  // one request through the input channel, with random idle in front;
  // valid stays up after the accept until the caller drives the next item or idles
  task automatic send_request(logic [1:0] req, logic [KEY_W-1:0] k,
                              logic [VALUE_BITS-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    key <= k;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    answers_due.push_back(table_apply(req, k, v));
  endtask

  // receiver: random stalls, or a long hold while recv_hold is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_a = answers_due.pop_front();
        if (status !== exp_a.st) begin
          $error("status expected %0d actual %0d", exp_a.st, status);
          fail_count++;
        end
        if (found_value !== exp_a.fv) begin
          $error("found_value expected %h actual %h", exp_a.fv, found_value);
          fail_count++;
        end
        if (occupied_count !== exp_a.cnt) begin
          $error("occupied_count expected %0d actual %0d", exp_a.cnt, occupied_count);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // apb write of the size register, only while idle
  task automatic write_size(logic [6:0] sz);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SIZE;
    pwdata <= {25'd0, sz};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    size_reg = sz;
  endtask

  // random key: 0..8 nonzero bytes, sometimes junk after a zero byte
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int               n;
    k = {$urandom, $urandom};
    n = $urandom_range(8);
    for (int b = 0; b < 8; b++) begin
      if (b < n && k[8*b +: 8] == 0) k[8*b +: 8] = 8'h5a;
      if (b == n) k[8*b +: 8] = 8'h00;
    end
    if ($urandom_range(3) != 0 && n < 8)
      for (int b = n + 1; b < 8; b++) k[8*b +: 8] = 8'h00;
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(3) == 0) return random_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic random_burst(int n);
    logic [KEY_W-1:0] k;
    int               r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = pick_key();
      if (r < 45) begin
        send_request(REQ_INSERT, k, $urandom);
        if (key_pool.size() < 100) key_pool.push_back(k);
      end else if (r < 75) begin
        send_request(REQ_SEARCH, k, $urandom);
      end else if (r < 97) begin
        send_request(REQ_DELETE, k, $urandom);
      end else begin
        send_request(REQ_UNDEFINED, k, $urandom);
      end
    end
  endtask

  task automatic test_directed();
    send_request(REQ_SEARCH, 64'd0, 32'd0);
    send_request(REQ_INSERT, 64'd0, 32'hffff_ffff);
    send_request(REQ_SEARCH, 64'hff00_0000_0000_0000, 32'd0);
    send_request(REQ_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_request(REQ_SEARCH, 64'hffff_ffff_ffff_ffff, 32'h1);
    send_request(REQ_INSERT, 64'h0000_0000_0000_0041, 32'h1234_5678);
    send_request(REQ_INSERT, 64'h1111_0000_0000_0041, 32'h8765_4321);
    send_request(REQ_SEARCH, 64'h0000_0000_0000_0041, 32'h0);
    send_request(REQ_UNDEFINED, 64'h41, 32'hdead_beef);
    send_request(REQ_DELETE, 64'h41, 32'h0);
    send_request(REQ_DELETE, 64'h41, 32'h0);
    send_request(REQ_SEARCH, 64'h41, 32'h0);
    send_request(REQ_INSERT, 64'h0102_0304_0506_0708, 32'haaaa_5555);
    send_request(REQ_DELETE, 64'd0, 32'h0);
    send_request(REQ_SEARCH, 64'hffff_ffff_ffff_ffff, 32'h0);
  endtask

  // small tables: fill up, table-full answer, tombstone reuse
  task automatic test_small_tables();
    write_size(7'd0);
    for (int i = 0; i < 4; i++) send_request(REQ_INSERT, 64'h61 + i, $urandom);
    send_request(REQ_DELETE, 64'h61, 32'h0);
    send_request(REQ_INSERT, 64'h62, 32'h7);
    write_size(7'd3);
    for (int i = 0; i < 6; i++) send_request(REQ_INSERT, 64'h71 + i, $urandom);
    send_request(REQ_DELETE, 64'h71, 32'h0);
    send_request(REQ_INSERT, 64'h7f, 32'h9);
    random_burst(60);
    write_size(7'd127);
    random_burst(60);
  endtask

  // long receiver hold so the block backs up and stalls its input
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (1500) @(posedge clk);
        recv_hold = 1'b0;
      end
      random_burst(10);
    join
  endtask

  task automatic test_random_phases();
    logic [6:0] sizes [4] = '{7'd64, 7'd5, 7'd17, 7'd1};
    int         idle_of [4] = '{0, 80, 0, 38};
    int         stall_of [4] = '{0, 0, 80, 38};
    for (int p = 0; p < 4; p++) begin
      write_size(sizes[p]);
      send_idle_pct = idle_of[p];
      recv_stall_pct = stall_of[p];
      random_burst(190);
    end
    write_size(7'd64);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_burst(80);
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    size_reg = 7'd64;
    tbl_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_state[i] = ST_EMPTY;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_small_tables();
    test_backpressure();
    test_random_phases();
    wait_drained();
    if (fail_count == 0) begin
      $display("quadratic_probe_hash_table_unit regression: pass");
    end else begin
      $display("quadratic_probe_hash_table_unit regression: fail");
    end
    $finish;
  end
endmodule

### sim.f
sv/qph_pkg.sv
sv/qph_ram.sv
sv/quadratic_probe_hash_table_unit.sv
sv/qph_checker.sv
dv/quadratic_probe_hash_table_unit_test.sv
